>>> rtl/feba_pkg.sv
// Package of the elementwise floating-point unit: depth of the stored operand,
// operation and register codes, and the request/response structs of the arithmetic core.
// No dependencies.
`default_nettype none
package feba_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_OPERATION      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STORED_ON_LEFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STORED_LENGTH  = 2'd2;

  localparam logic [0:0] KIND_LOAD    = 1'b0;
  localparam logic [0:0] KIND_COMPUTE = 1'b1;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [30:0] INF_MAG   = 31'h7F80_0000;

  typedef struct packed {
    logic        start;
    logic [1:0]  op;
    logic [31:0] lhs;
    logic [31:0] rhs;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } fpu_rsp_t;

endpackage
`default_nettype wire

>>> rtl/feba_in_if.sv
// Input channel of the elementwise unit: valid/ready handshake with kind, operand, last.
// No dependencies.
`default_nettype none
interface feba_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] operand;
  logic        last;

  modport source (output valid, kind, operand, last, input ready);
  modport sink   (input valid, kind, operand, last, output ready);
endinterface
`default_nettype wire

>>> rtl/feba_out_if.sv
// Result channel of the elementwise unit: valid/ready handshake with result and result_last.
// No dependencies.
`default_nettype none
interface feba_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        result_last;

  modport source (output valid, result, result_last, input ready);
  modport sink   (input valid, result, result_last, output ready);
endinterface
`default_nettype wire

>>> rtl/feba_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module feba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/feba_fpu.sv
// Multi-cycle binary32 add/subtract/multiply/divide core with round to nearest even.
// Depends on feba_pkg.
`default_nettype none
module feba_fpu import feba_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire fpu_req_t req,
  output      fpu_rsp_t rsp
);

  typedef enum logic [2:0] {
    F_IDLE, F_PREP, F_DNORM, F_DIV, F_NORM, F_ROUND
  } fstate_t;

  fstate_t            state_r;
  logic [1:0]         op_r;
  logic [31:0]        a_r, b_r;
  logic [23:0]        ma_r, mb_r;
  logic signed [10:0] ea_r, eb_r;
  logic [26:0]        q_r;
  logic [24:0]        rem_r;
  logic [4:0]         cnt_r;
  logic [49:0]        wm_r;
  logic signed [10:0] we_r;
  logic               sticky_r;
  logic               sign_r;
  logic [31:0]        res_r;
  logic               done_r;

  // Operand decode.
  logic [7:0]  ea_f, eb_f;
  logic [22:0] fa, fb;
  logic        sa, sb, sbe, sx;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [23:0] ma, mb;
  logic [7:0]  ea_e, eb_e;

  always_comb begin
    ea_f   = a_r[30:23];
    eb_f   = b_r[30:23];
    fa     = a_r[22:0];
    fb     = b_r[22:0];
    sa     = a_r[31];
    sb     = b_r[31];
    sbe    = sb ^ (op_r == OP_SUB);
    sx     = sa ^ sb;
    a_nan  = (ea_f == 8'hFF) && (fa != 23'd0);
    b_nan  = (eb_f == 8'hFF) && (fb != 23'd0);
    a_inf  = (ea_f == 8'hFF) && (fa == 23'd0);
    b_inf  = (eb_f == 8'hFF) && (fb == 23'd0);
    a_zero = (a_r[30:0] == 31'd0);
    b_zero = (b_r[30:0] == 31'd0);
    ma     = {ea_f != 8'd0, fa};
    mb     = {eb_f != 8'd0, fb};
    ea_e   = (ea_f == 8'd0) ? 8'd1 : ea_f;
    eb_e   = (eb_f == 8'd0) ? 8'd1 : eb_f;
  end

  // Special operands decide the result directly.
  logic        spec;
  logic [31:0] spec_val;

  always_comb begin
    spec     = 1'b1;
    spec_val = QNAN_BITS;
    if (a_nan || b_nan) begin
      spec_val = QNAN_BITS;
    end else begin
      case (op_r)
        OP_ADD, OP_SUB: begin
          if (a_inf && b_inf) begin
            spec_val = (sa != sbe) ? QNAN_BITS : {sa, INF_MAG};
          end else if (a_inf) begin
            spec_val = {sa, INF_MAG};
          end else if (b_inf) begin
            spec_val = {sbe, INF_MAG};
          end else begin
            spec = 1'b0;
          end
        end
        OP_MUL: begin
          if ((a_inf && b_zero) || (b_inf && a_zero)) begin
            spec_val = QNAN_BITS;
          end else if (a_inf || b_inf) begin
            spec_val = {sx, INF_MAG};
          end else begin
            spec = 1'b0;
          end
        end
        default: begin
          if ((a_zero && b_zero) || (a_inf && b_inf)) begin
            spec_val = QNAN_BITS;
          end else if (a_inf || b_zero) begin
            spec_val = {sx, INF_MAG};
          end else if (b_inf || a_zero) begin
            spec_val = {sx, 31'd0};
          end else begin
            spec = 1'b0;
          end
        end
      endcase
    end
  end

  // Alignment and add of the two magnitudes; the smaller operand is jammed.
  logic        a_big;
  logic [7:0]  el, es, d;
  logic [23:0] ml, ms;
  logic        sl, ss;
  logic [49:0] big_w, small_w, shifted_w, jam_w, sum_w;

  always_comb begin
    a_big     = (a_r[30:0] >= b_r[30:0]);
    el        = a_big ? ea_e : eb_e;
    es        = a_big ? eb_e : ea_e;
    ml        = a_big ? ma : mb;
    ms        = a_big ? mb : ma;
    sl        = a_big ? sa : sbe;
    ss        = a_big ? sbe : sa;
    d         = el - es;
    big_w     = {1'b0, ml, 25'd0};
    small_w   = {1'b0, ms, 25'd0};
    shifted_w = small_w >> d;
    jam_w     = shifted_w | {49'd0, (shifted_w << d) != small_w};
    sum_w     = (sl != ss) ? (big_w - jam_w) : (big_w + jam_w);
  end

  logic [47:0] prod;
  assign prod = ma * mb;

  // Division step.
  logic        ge;
  logic [24:0] diff;
  logic [26:0] q_nxt;

  always_comb begin
    ge    = (rem_r >= {1'b0, mb_r});
    diff  = ge ? (rem_r - {1'b0, mb_r}) : rem_r;
    q_nxt = {q_r[25:0], ge};
  end

  // Rounding.
  logic [23:0]        m24;
  logic               g, s, inc;
  logic [24:0]        rsum;
  logic signed [10:0] fld;

  always_comb begin
    m24  = wm_r[48:25];
    g    = wm_r[24];
    s    = sticky_r | (|wm_r[23:0]);
    inc  = g & (s | m24[0]);
    rsum = {1'b0, m24} + {24'd0, inc};
    fld  = (rsum[24] || rsum[23]) ? (we_r + $signed({10'd0, rsum[24]})) : 11'sd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        F_IDLE: begin
          done_r <= 1'b0;
          if (req.start) begin
            a_r     <= req.lhs;
            b_r     <= req.rhs;
            op_r    <= req.op;
            state_r <= F_PREP;
          end
        end
        F_PREP: begin
          sticky_r <= 1'b0;
          if (spec) begin
            res_r   <= spec_val;
            done_r  <= 1'b1;
            state_r <= F_IDLE;
          end else begin
            case (op_r)
              OP_ADD, OP_SUB: begin
                wm_r    <= sum_w;
                we_r    <= $signed({3'd0, el});
                sign_r  <= (sum_w == 50'd0) ? (sa & sbe) : sl;
                state_r <= F_NORM;
              end
              OP_MUL: begin
                wm_r    <= {prod, 2'b00};
                we_r    <= $signed({3'd0, ea_e}) + $signed({3'd0, eb_e}) - 11'sd127;
                sign_r  <= sx;
                state_r <= F_NORM;
              end
              default: begin
                ma_r    <= ma;
                mb_r    <= mb;
                ea_r    <= $signed({3'd0, ea_e});
                eb_r    <= $signed({3'd0, eb_e});
                sign_r  <= sx;
                state_r <= F_DNORM;
              end
            endcase
          end
        end
        F_DNORM: begin
          // Subnormal divide operands are brought to a leading one first.
          if (!ma_r[23]) begin
            ma_r <= {ma_r[22:0], 1'b0};
            ea_r <= ea_r - 11'sd1;
          end
          if (!mb_r[23]) begin
            mb_r <= {mb_r[22:0], 1'b0};
            eb_r <= eb_r - 11'sd1;
          end
          if (ma_r[23] && mb_r[23]) begin
            rem_r   <= {1'b0, ma_r};
            q_r     <= 27'd0;
            cnt_r   <= 5'd26;
            we_r    <= ea_r - eb_r + 11'sd127;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          q_r   <= q_nxt;
          rem_r <= {diff[23:0], 1'b0};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            wm_r     <= {1'b0, q_nxt, 22'd0};
            sticky_r <= (diff != 25'd0);
            state_r  <= F_NORM;
          end
        end
        F_NORM: begin
          if (wm_r[49]) begin
            wm_r     <= wm_r >> 1;
            sticky_r <= sticky_r | wm_r[0];
            we_r     <= we_r + 11'sd1;
          end else if (we_r < -11'sd60) begin
            // Far below the subnormal range: every bit ends up in the sticky bit.
            sticky_r <= sticky_r | (|wm_r);
            wm_r     <= 50'd0;
            we_r     <= 11'sd1;
          end else if (we_r < 11'sd1) begin
            wm_r     <= wm_r >> 1;
            sticky_r <= sticky_r | wm_r[0];
            we_r     <= we_r + 11'sd1;
          end else if (!wm_r[48] && (wm_r != 50'd0) && (we_r > 11'sd1)) begin
            wm_r <= wm_r << 1;
            we_r <= we_r - 11'sd1;
          end else begin
            state_r <= F_ROUND;
          end
        end
        F_ROUND: begin
          if (fld >= 11'sd255) begin
            res_r <= {sign_r, INF_MAG};
          end else begin
            res_r <= {sign_r, fld[7:0], rsum[22:0]};
          end
          done_r  <= 1'b1;
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

endmodule
`default_nettype wire

>>> rtl/float_elementwise_broadcast_alu_top.sv
// Top level of the elementwise binary32 unit: stored operand memory, pointers,
// configuration registers and output register. Depends on feba_pkg, the channel
// interfaces, feba_ram and feba_fpu.
//
// Usage: load transfers (kind 0) write the stored operand one element at a time;
// a load with last set rewinds both the load pointer and the read index. Compute
// transfers (kind 1) pair the streamed operand with the stored element at the
// read index, which wraps at stored_length, and give one result transfer each,
// with result_last echoing last. Load transfers give no result.
// Configuration (operation, stored_on_left, stored_length) is written through the
// cfg_ port; the user must do so only while the unit is idle, unchecked by the block.
// Sequence: loads are accepted one per cycle while no compute item is in flight. A
// compute item goes through the fetch of the stored element and the core's prepare
// step, where a special operand (NaN, infinity, zero divisor) decides the result
// at once. Otherwise an add or multiply goes on to normalization, one bit of shift
// per step, and rounding; a divide first brings its operands to a leading one and
// forms the quotient one bit per step. The result then passes a hold state into
// the output register. One compute item is in flight at a time; the next item is
// accepted the cycle after its result enters the output register.
// The result sits in an output register, so a new item is accepted while an
// earlier result still waits for the receiver; a stalled receiver holds the
// result and the unit stops only when a second result is ready to leave.
// Reset (rst_n low at a clock edge) clears pointers, configuration and the
// handshake state; the stored operand holds no defined value until loaded.
`default_nettype none
module float_elementwise_broadcast_alu_top import feba_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  feba_in_if.sink                    in_chan,
  feba_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_BUSY, S_HOLD} state_t;

  state_t            state_r;
  logic [1:0]        operation_r;
  logic              stored_on_left_r;
  logic [LEN_W-1:0]  stored_length_r;
  logic [ADDR_W-1:0] load_ptr_r;
  logic [ADDR_W-1:0] read_idx_r;
  logic [31:0]       streamed_r;
  logic              last_r;
  logic [31:0]       pend_r;
  logic              out_valid_r;
  logic [31:0]       out_result_r;
  logic              out_last_r;

  // Effective wrap length: zero acts as one, anything above the depth as the depth.
  logic [LEN_W-1:0]  eff_len;
  logic [ADDR_W-1:0] cur_idx;
  logic [LEN_W-1:0]  idx_inc;
  logic [ADDR_W:0]   lp_inc;
  logic              accept, is_load;
  logic              out_free;

  always_comb begin
    if (stored_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (stored_length_r > LEN_W'(STORE_DEPTH)) begin
      eff_len = LEN_W'(STORE_DEPTH);
    end else begin
      eff_len = stored_length_r;
    end
    cur_idx = ({{(LEN_W-ADDR_W){1'b0}}, read_idx_r} >= eff_len) ? '0 : read_idx_r;
    idx_inc = {{(LEN_W-ADDR_W){1'b0}}, cur_idx} + LEN_W'(1);
    lp_inc  = {1'b0, load_ptr_r} + (ADDR_W+1)'(1);
    accept  = in_chan.valid && in_chan.ready;
    is_load = (in_chan.kind == KIND_LOAD);
    out_free = !out_valid_r || out_chan.ready;
  end

  assign in_chan.ready = (state_r == S_IDLE);

  // Stored operand memory: written by loads, read at the accept of a compute.
  logic [31:0] ram_rdata;

  feba_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .en    (accept),
    .we    (is_load),
    .addr  (is_load ? load_ptr_r : cur_idx),
    .wdata (in_chan.operand),
    .rdata (ram_rdata)
  );

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  always_comb begin
    fpu_req.start = (state_r == S_FETCH);
    fpu_req.op    = operation_r;
    fpu_req.lhs   = stored_on_left_r ? ram_rdata : streamed_r;
    fpu_req.rhs   = stored_on_left_r ? streamed_r : ram_rdata;
  end

  feba_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      operation_r      <= OP_ADD;
      stored_on_left_r <= 1'b0;
      stored_length_r  <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OPERATION:      operation_r      <= cfg_data[1:0];
        CFG_STORED_ON_LEFT: stored_on_left_r <= cfg_data[0];
        CFG_STORED_LENGTH:  stored_length_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, pointers and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_ptr_r  <= '0;
      read_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_HOLD a taken result is replaced by the pending one below.
      if (out_valid_r && out_chan.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (in_chan.last || (lp_inc == (ADDR_W+1)'(STORE_DEPTH))) begin
                load_ptr_r <= '0;
              end else begin
                load_ptr_r <= lp_inc[ADDR_W-1:0];
              end
              if (in_chan.last) begin
                read_idx_r <= '0;
              end
            end else begin
              streamed_r <= in_chan.operand;
              last_r     <= in_chan.last;
              if (in_chan.last || (idx_inc >= eff_len)) begin
                read_idx_r <= '0;
              end else begin
                read_idx_r <= idx_inc[ADDR_W-1:0];
              end
              state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: state_r <= S_BUSY;
        S_BUSY: begin
          if (fpu_rsp.done) begin
            pend_r  <= fpu_rsp.result;
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_result_r <= pend_r;
            out_last_r   <= last_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result      = out_result_r;
  assign out_chan.result_last = out_last_r;

endmodule
`default_nettype wire
